// ===== src/dct_2d_block_macros.svh =====
// ----------------------------------------------------------------------------
// dct_2d_block_macros
// Assertion macros shared by the transform block.
// ----------------------------------------------------------------------------
`ifndef DCT_2D_BLOCK_MACROS_SVH
`define DCT_2D_BLOCK_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define DCT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define DCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/dct2d_pkg.sv =====
// ----------------------------------------------------------------------------
// dct2d_pkg
// Types and constants of the 2D DCT-II block: sequencer states, pipeline tag,
// quarter-wave cosine ROM in Q14 and the fixed-point scaling.
// ----------------------------------------------------------------------------
`default_nettype none

package dct2d_pkg;

   localparam int DEFAULT_BLOCK_DIM = 8;
   localparam int FRAC_BITS         = 28;

   localparam logic signed [15:0] C0_Q14 = 16'sd11585;

   // Row (N-2), entry k = round(cos(pi k / 2N) * 2^14), k = 0..N
   localparam logic [14:0] COS_ROM [0:6][0:8] = '{
      '{15'd16384, 15'd11585, 15'd0,     15'd0,     15'd0,
        15'd0,     15'd0,     15'd0,     15'd0},
      '{15'd16384, 15'd14189, 15'd8192,  15'd0,     15'd0,
        15'd0,     15'd0,     15'd0,     15'd0},
      '{15'd16384, 15'd15137, 15'd11585, 15'd6270,  15'd0,
        15'd0,     15'd0,     15'd0,     15'd0},
      '{15'd16384, 15'd15582, 15'd13255, 15'd9630,  15'd5063,
        15'd0,     15'd0,     15'd0,     15'd0},
      '{15'd16384, 15'd15826, 15'd14189, 15'd11585, 15'd8192,
        15'd4240,  15'd0,     15'd0,     15'd0},
      '{15'd16384, 15'd15973, 15'd14761, 15'd12810, 15'd10215,
        15'd7109,  15'd3646,  15'd0,     15'd0},
      '{15'd16384, 15'd16069, 15'd15137, 15'd13623, 15'd11585,
        15'd9102,  15'd6270,  15'd3196,  15'd0}
   };

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_RUN,
      ST_DRAIN
   } dct2d_state_type;

   // Travels with each multiply-accumulate term down the pipeline
   typedef struct packed {
      logic first;       // first term of a coefficient
      logic last_term;   // last term of a coefficient
      logic last_coef;   // last term of the last coefficient of the block
   } mac_tag_type;

endpackage

`default_nettype wire

// ===== src/dct_2d_block.sv =====
// After the beat carrying the last pixel, the sequencer issues the N*N terms of
// each coefficient in turn; each leaves the MAC pipeline and output register
// after its last term. Throughput: one pixel per cycle while loading, then the
// transform, set by the single multiply-accumulate path fed from the pixel RAM.
// Reset (synchronous, active high) returns to loading with an empty block.
// Results cannot be held off: each is shown for exactly one cycle.
`default_nettype none

`include "dct_2d_block_macros.svh"

// ----------------------------------------------------------------------------
// dct_2d_block
// Unnormalised 8x8 (N x N) 2D DCT-II of gray pixels. Pixels are stored in a
// block RAM in row-major order; a sequencer then walks u, v, i, j and drives a
// shared multiply-accumulate pipeline that reads the RAM once per term.
// ----------------------------------------------------------------------------
module dct_2d_block
   import dct2d_pkg::*;
#(
   parameter int BLOCK_DIM = DEFAULT_BLOCK_DIM
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  wire  [7:0]               req_pixel,
   output logic                     rsp_valid,
   output logic signed [15:0]       rsp_coefficient,
   output logic                     rsp_last_coefficient
);

   // ------------------------------------------------------------------------
   // Derived sizes
   // ------------------------------------------------------------------------
   localparam int DEPTH    = BLOCK_DIM * BLOCK_DIM;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int IDX_W    = $clog2(BLOCK_DIM);
   localparam int PHASE_W  = $clog2(4 * BLOCK_DIM);   // phase runs modulo 4N
   localparam int PW1      = PHASE_W + 1;
   localparam int ROM_ROW  = BLOCK_DIM - 2;
   localparam int PA_W     = 25;                      // weight x pixel
   localparam int PB_W     = 41;                      // weight x weight x pixel
   localparam int ACC_W    = PB_W + 6;                // up to 64 terms per sum
   localparam int Q_W      = ACC_W - FRAC_BITS;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(BLOCK_DIM - 1);
   localparam logic [PW1-1:0]    QUART     = PW1'(BLOCK_DIM);
   localparam logic [PW1-1:0]    HALF      = PW1'(2 * BLOCK_DIM);
   localparam logic [PW1-1:0]    THREEQ    = PW1'(3 * BLOCK_DIM);
   localparam logic [PW1-1:0]    FULL      = PW1'(4 * BLOCK_DIM);

   localparam logic signed [ACC_W-1:0] ROUND_BIAS =
      {{(ACC_W - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
   localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(32768);

   // ------------------------------------------------------------------------
   // Q14 weight for phase m = k(2n+1) mod 4N; c(0) is folded in for k = 0.
   // Fold the full period onto the quarter-wave table.
   // ------------------------------------------------------------------------
   function automatic logic signed [15:0] weight_of(input logic dc,
                                                    input logic [PHASE_W-1:0] m);
      logic [PW1-1:0] mm;
      logic [PW1-1:0] idx;
      logic           neg;
      logic [14:0]    mag;
      mm = PW1'(m);
      if (mm <= QUART) begin
         idx = mm;
         neg = 1'b0;
      end else if (mm <= HALF) begin
         idx = HALF - mm;
         neg = 1'b1;
      end else if (mm <= THREEQ) begin
         idx = mm - HALF;
         neg = 1'b1;
      end else begin
         idx = FULL - mm;
         neg = 1'b0;
      end
      mag = COS_ROM[ROM_ROW][idx[3:0]];
      if (dc) begin
         return C0_Q14;
      end
      return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

   // Advance a phase by 2k, wrapping modulo 4N (2k < 4N, one subtract is enough)
   function automatic logic [PHASE_W-1:0] phase_step(input logic [PHASE_W-1:0] ph,
                                                     input logic [IDX_W-1:0]   k);
      logic [PW1-1:0] sum;
      sum = PW1'(ph) + PW1'({k, 1'b0});
      if (sum >= FULL) begin
         sum = sum - FULL;
      end
      return sum[PHASE_W-1:0];
   endfunction

   // ------------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------------
   dct2d_state_type   state_ff, state_in;
   logic [ADDR_W-1:0] load_count_ff, load_count_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [IDX_W-1:0]  u_ff, u_in;
   logic [IDX_W-1:0]  v_ff, v_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [PHASE_W-1:0] phase_u_ff, phase_u_in;
   logic [PHASE_W-1:0] phase_v_ff, phase_v_in;

   logic        accept;
   logic        block_done;
   logic        issue;
   mac_tag_type issue_tag;

   // Pipeline stages
   logic                    valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   mac_tag_type             tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   logic signed [15:0]      wu_ff, wv_ff, wv2_ff;
   logic [7:0]              pix_q_ff;
   logic signed [PA_W-1:0]  proda_ff, proda_in;
   logic signed [PB_W-1:0]  prodb_ff, prodb_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_coef_ff, rsp_coef_in;
   logic              rsp_last_ff, rsp_last_in;

   logic signed [ACC_W-1:0] biased;
   logic signed [Q_W-1:0]   quot;

   // Pixel RAM, one write port for loading and one registered read port
   logic [7:0] pix_mem [0:DEPTH-1];

   assign accept     = start && !busy;
   assign block_done = accept && (load_count_ff == LAST_ADDR);

   // ------------------------------------------------------------------------
   // Sequencer: next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (block_done) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue_tag.last_coef) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // hold until the last coefficient has left the output register
            if (rsp_valid_ff && rsp_last_ff) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Sequencer: outputs
   always_comb begin
      busy  = 1'b1;
      issue = 1'b0;
      case (state_ff)
         ST_LOAD:  busy  = 1'b0;
         ST_RUN:   issue = 1'b1;
         ST_DRAIN: busy  = 1'b1;
         default:  busy  = 1'b1;
      endcase
   end

   // Tag of the term issued this cycle
   always_comb begin
      issue_tag.first     = (rd_addr_ff == '0);
      issue_tag.last_term = (rd_addr_ff == LAST_ADDR);
      issue_tag.last_coef = issue && (rd_addr_ff == LAST_ADDR) &&
                            (u_ff == LAST_IDX) && (v_ff == LAST_IDX);
   end

   // ------------------------------------------------------------------------
   // Index and phase counters: j innermost, then i (via the read address),
   // then v, then u. Phases track k(2n+1) mod 4N without a divider.
   // ------------------------------------------------------------------------
   always_comb begin
      load_count_in = load_count_ff;
      rd_addr_in    = rd_addr_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      j_in          = j_ff;
      phase_u_in    = phase_u_ff;
      phase_v_in    = phase_v_ff;

      if (accept) begin
         load_count_in = block_done ? '0 : load_count_ff + 1'b1;
      end

      if (block_done) begin
         rd_addr_in = '0;
         u_in       = '0;
         v_in       = '0;
         j_in       = '0;
         phase_u_in = '0;
         phase_v_in = '0;
      end else if (issue) begin
         rd_addr_in = rd_addr_ff + 1'b1;
         j_in       = j_ff + 1'b1;
         phase_v_in = phase_step(phase_v_ff, v_ff);
         if (j_ff == LAST_IDX) begin
            // next row of the block
            j_in       = '0;
            phase_v_in = PHASE_W'(v_ff);
            phase_u_in = phase_step(phase_u_ff, u_ff);
         end
         if (rd_addr_ff == LAST_ADDR) begin
            // next coefficient
            rd_addr_in = '0;
            j_in       = '0;
            if (v_ff == LAST_IDX) begin
               v_in = '0;
               u_in = u_ff + 1'b1;
            end else begin
               v_in = v_ff + 1'b1;
            end
            phase_u_in = PHASE_W'(u_in);
            phase_v_in = PHASE_W'(v_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         load_count_ff <= '0;
         rd_addr_ff    <= '0;
         u_ff          <= '0;
         v_ff          <= '0;
         j_ff          <= '0;
         phase_u_ff    <= '0;
         phase_v_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         rd_addr_ff    <= rd_addr_in;
         u_ff          <= u_in;
         v_ff          <= v_in;
         j_ff          <= j_in;
         phase_u_ff    <= phase_u_in;
         phase_v_ff    <= phase_v_in;
      end
   end

   // ------------------------------------------------------------------------
   // Pixel RAM. Loading and reading never overlap: reads run only once the
   // block is complete, so no forwarding is needed.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_mem[load_count_ff] <= req_pixel;
      end
      pix_q_ff <= pix_mem[rd_addr_ff];
   end

   // ------------------------------------------------------------------------
   // MAC pipeline
   //   stage 1: weights looked up, pixel read from RAM
   //   stage 2: weight(u,i) x pixel
   //   stage 3: x weight(v,j)
   //   stage 4: accumulate exactly
   // ------------------------------------------------------------------------
   assign proda_in = PA_W'(wu_ff) * PA_W'($signed({1'b0, pix_q_ff}));
   assign prodb_in = PB_W'(proda_ff) * PB_W'(wv2_ff);
   assign acc_in   = tag3_ff.first ? ACC_W'(prodb_ff) : acc_ff + ACC_W'(prodb_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         valid1_ff <= issue;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      tag1_ff  <= issue_tag;
      wu_ff    <= weight_of(u_ff == '0, phase_u_ff);
      wv_ff    <= weight_of(v_ff == '0, phase_v_ff);
      tag2_ff  <= tag1_ff;
      proda_ff <= proda_in;
      wv2_ff   <= wv_ff;
      tag3_ff  <= tag2_ff;
      prodb_ff <= prodb_in;
      tag4_ff  <= tag3_ff;
      if (valid3_ff) begin
         acc_ff <= acc_in;
      end
   end

   // ------------------------------------------------------------------------
   // Scale: drop the Q28 fraction truncating toward zero (bias negatives
   // before the arithmetic shift), then saturate to 16 bits.
   // ------------------------------------------------------------------------
   assign biased = acc_ff + (acc_ff[ACC_W-1] ? ROUND_BIAS : '0);
   assign quot   = $signed(biased[ACC_W-1:FRAC_BITS]);

   always_comb begin
      rsp_valid_in = valid4_ff && tag4_ff.last_term;
      rsp_last_in  = tag4_ff.last_coef;
      if (quot > Q_MAX) begin
         rsp_coef_in = 16'sh7FFF;
      end else if (quot < Q_MIN) begin
         rsp_coef_in = -16'sh8000;
      end else begin
         rsp_coef_in = quot[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_coef_ff <= rsp_coef_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_coefficient      = rsp_coef_ff;
   assign rsp_last_coefficient = rsp_valid_ff && rsp_last_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `DCT_ASSERT_NEXT(a_busy_after_block, block_done, state_ff == ST_RUN, "run not started")
   `DCT_ASSERT_NOW(a_beat_only_busy, rsp_valid || valid1_ff, busy, "beat while loading")
   `DCT_ASSERT_NEXT(a_idle_after_last, rsp_last_coefficient, !busy && !valid1_ff, "not idle")
   `DCT_ASSERT_NOW(a_no_load_when_busy, busy, load_count_ff == '0, "load count moved")

endmodule

`default_nettype wire

// ===== dv/dct_2d_block_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dct_2d_block_checker
// Watches the pixel and coefficient channels of the transform block. Mirrors
// the pixel store, forms the expected N x N coefficients once a block is
// complete and compares every coefficient beat against them in order.
// ----------------------------------------------------------------------------
module dct_2d_block_checker #(
   parameter int BLOCK_DIM = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [7:0]         req_pixel,
   input  logic               rsp_valid,
   input  logic signed [15:0] rsp_coefficient,
   input  logic               rsp_last_coefficient,
   output int                 error_count,
   output int                 open_count,
   output int                 coef_count
);

   localparam int BLOCK_PIXELS = BLOCK_DIM * BLOCK_DIM;
   localparam int SCALE_SHIFT  = 28;

   typedef struct packed {
      logic signed [15:0] coefficient;
      logic               last_coefficient;
   } coef_beat_type;

   logic [7:0]     pixel_mirror [0:BLOCK_PIXELS-1];
   int             pixels_loaded;
   int             mismatches;
   int             compared;
   int             quarter_q14 [0:8];
   int             dc_weight_q14;
   coef_beat_type  coef_queue [$];
   coef_beat_type  want;

   // Quarter-wave cosine table in Q14, built from the real cosine
   initial begin
      for (int k = 0; k <= 8; k++)
         quarter_q14[k] =
            $rtoi($cos(3.14159265358979 * k / (2.0 * BLOCK_DIM)) * 16384.0 + 0.5);
      dc_weight_q14 = $rtoi(16384.0 / $sqrt(2.0) + 0.5);
      pixels_loaded = 0;
      mismatches    = 0;
      compared      = 0;
      error_count   = 0;
      open_count    = 0;
      coef_count    = 0;
   end

   // Q14 basis weight of frequency k at sample n, DC scale folded in
   function automatic longint basis_weight(int k, int n);
      int m;
      if (k == 0)
         return dc_weight_q14;
      m = (k * (2 * n + 1)) % (4 * BLOCK_DIM);
      if (m <= BLOCK_DIM)
         return quarter_q14[m];
      else if (m <= 2 * BLOCK_DIM)
         return -quarter_q14[2 * BLOCK_DIM - m];
      else if (m <= 3 * BLOCK_DIM)
         return -quarter_q14[m - 2 * BLOCK_DIM];
      return quarter_q14[4 * BLOCK_DIM - m];
   endfunction

   task automatic predict_coefficients();
      longint        acc;
      longint        mag;
      longint        q;
      coef_beat_type beat;
      for (int u = 0; u < BLOCK_DIM; u++) begin
         for (int v = 0; v < BLOCK_DIM; v++) begin
            acc = 0;
            for (int i = 0; i < BLOCK_DIM; i++)
               for (int j = 0; j < BLOCK_DIM; j++)
                  acc += basis_weight(u, i) * basis_weight(v, j)
                         * longint'(pixel_mirror[i * BLOCK_DIM + j]);
            mag = (acc < 0) ? -acc : acc;
            mag = mag >>> SCALE_SHIFT;
            q   = (acc < 0) ? -mag : mag;
            if (q > 32767)
               q = 32767;
            if (q < -32768)
               q = -32768;
            beat.coefficient      = q[15:0];
            beat.last_coefficient = (u == BLOCK_DIM - 1) && (v == BLOCK_DIM - 1);
            coef_queue.push_back(beat);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            pixel_mirror[pixels_loaded] = req_pixel;
            pixels_loaded++;
            if (pixels_loaded == BLOCK_PIXELS) begin
               pixels_loaded = 0;
               predict_coefficients();
            end
         end
         if ($isunknown(rsp_valid)) begin
            $error("rsp_valid unknown");
            mismatches++;
         end else if (rsp_valid) begin
            if (coef_queue.size() == 0) begin
               $error("coefficient %0d with none expected", rsp_coefficient);
               mismatches++;
            end else begin
               want = coef_queue.pop_front();
               compared++;
               if (rsp_coefficient !== want.coefficient) begin
                  $error("coefficient: expected %0d, actual %0d",
                         want.coefficient, rsp_coefficient);
                  mismatches++;
               end
               if (rsp_last_coefficient !== want.last_coefficient) begin
                  $error("last_coefficient: expected %0b, actual %0b",
                         want.last_coefficient, rsp_last_coefficient);
                  mismatches++;
               end
            end
         end
         error_count <= mismatches;
         open_count  <= coef_queue.size();
         coef_count  <= compared;
      end
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Pixel stream test of the 2D DCT block: loads whole blocks of directed and
// patterned random pixels under varying sender gaps, with a side checker
// predicting and comparing every coefficient.
// ----------------------------------------------------------------------------
module tb
   import dct2d_pkg::*;
();

   localparam int BLOCK_DIM    = DEFAULT_BLOCK_DIM;
   localparam int BLOCK_PIXELS = BLOCK_DIM * BLOCK_DIM;
   // About 300 pixels, rounded up to whole blocks so every block completes
   localparam int BLOCK_TOTAL  = (300 + BLOCK_PIXELS - 1) / BLOCK_PIXELS;
   localparam int PIXEL_TOTAL  = BLOCK_TOTAL * BLOCK_PIXELS;
   localparam int DRAIN_CYCLES = 2 * BLOCK_PIXELS + 10;

   typedef enum int {
      PAT_NOISE,
      PAT_FLAT,
      PAT_CHECKER,
      PAT_RAMP,
      PAT_EXTREME
   } block_pattern_type;

   // Opening pixels: both extremes, a walking one, a walking zero and a few
   // alternating masks, so that every pixel bit is seen high and low
   localparam logic [7:0] OPENING_PIXELS [0:24] = '{
      8'd0,   8'd255,
      8'd1,   8'd2,   8'd4,   8'd8,   8'd16,  8'd32,  8'd64,  8'd128,
      8'd254, 8'd253, 8'd251, 8'd247, 8'd239, 8'd223, 8'd191, 8'd127,
      8'h55,  8'hAA,  8'h0F,  8'hF0,  8'd128, 8'd127, 8'd255
   };

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [7:0]         req_pixel;
   logic               rsp_valid;
   logic signed [15:0] rsp_coefficient;
   logic               rsp_last_coefficient;

   int error_count;
   int open_count;
   int coef_count;

   dct_2d_block #(
      .BLOCK_DIM (BLOCK_DIM)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_pixel            (req_pixel),
      .rsp_valid            (rsp_valid),
      .rsp_coefficient      (rsp_coefficient),
      .rsp_last_coefficient (rsp_last_coefficient)
   );

   dct_2d_block_checker #(
      .BLOCK_DIM (BLOCK_DIM)
   ) scoreboard (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_pixel            (req_pixel),
      .rsp_valid            (rsp_valid),
      .rsp_coefficient      (rsp_coefficient),
      .rsp_last_coefficient (rsp_last_coefficient),
      .error_count          (error_count),
      .open_count           (open_count),
      .coef_count           (coef_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Hard stop well beyond the slowest legal run: each block needs the sender
   // gaps of its pixels plus the transform
   initial begin
      #3000000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      block_pattern_type pattern;
      logic [7:0]        pixel;
      logic [7:0]        flat_level;
      int                idle_pct;
      int                row;
      int                col;
      int                pos;

      reset     = 1'b1;
      start     = 1'b0;
      req_pixel = '0;
      pattern   = PAT_NOISE;
      flat_level = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int item = 0; item < PIXEL_TOTAL; item++) begin
         pos = item % BLOCK_PIXELS;
         row = pos / BLOCK_DIM;
         col = pos % BLOCK_DIM;

         // Pick the content style of each new block; force the harshest
         // ones early so they are never left to chance
         if (pos == 0) begin
            if (item / BLOCK_PIXELS == 1)
               pattern = PAT_CHECKER;
            else if (item / BLOCK_PIXELS == 2)
               pattern = PAT_FLAT;
            else
               pattern = block_pattern_type'($urandom_range(PAT_EXTREME, PAT_NOISE));
            case ($urandom_range(2))
               0: flat_level = 8'd0;
               1: flat_level = 8'd255;
               default: flat_level = 8'($urandom);
            endcase
            if (item / BLOCK_PIXELS == 2)
               flat_level = 8'd255;
         end

         if (item < $size(OPENING_PIXELS)) begin
            pixel = OPENING_PIXELS[item];
         end else begin
            case (pattern)
               PAT_FLAT:    pixel = flat_level;
               PAT_CHECKER: pixel = ((row + col) % 2 == 0) ? 8'd255 : 8'd0;
               PAT_RAMP:    pixel = 8'((pos * 255) / (BLOCK_PIXELS - 1));
               PAT_EXTREME: pixel = $urandom_range(1) ? 8'd255 : 8'd0;
               default:     pixel = 8'($urandom);
            endcase
         end

         // Sender gaps: light, then heavy, then none for the closing third
         case (item * 3 / PIXEL_TOTAL)
            0:       idle_pct = 8;
            1:       idle_pct = 45;
            default: idle_pct = 0;
         endcase
         if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end

         // Hold the beat until the block takes it; busy covers the transform
         req_pixel <= pixel;
         start     <= 1'b1;
         do @(posedge clock); while (busy !== 1'b0);
      end
      start <= 1'b0;

      // Drain: wait for every predicted coefficient, then let the pipe settle
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d pixels in %0d blocks of %0dx%0d, %0d coefficients compared.",
               PIXEL_TOTAL, BLOCK_TOTAL, BLOCK_DIM, BLOCK_DIM, coef_count);
      $display("Sender gaps ran at 8, 45 and 0 percent over flat, checker, ramp, noise.");
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/dct2d_pkg.sv
src/dct_2d_block.sv
dv/dct_2d_block_checker.sv
dv/tb.sv
